// ----- hw/rtl/rrss_pkg.sv -----
// ----------------------------------------------------------------------------
// rrss_pkg
// Shared types and constants for the round-robin slice scheduler.
// ----------------------------------------------------------------------------
package rrss_pkg;

	localparam int MAX_PROCS = 16;
	localparam int IDX_W     = $clog2(MAX_PROCS);
	localparam int CNT_W     = $clog2(MAX_PROCS + 1);

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_SLICE = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_SLICE    = 2'd0,
		ST_DONE     = 2'd1,
		ST_ACCEPTED = 2'd2,
		ST_REJECTED = 2'd3
	} status_t;

	localparam logic CFG_QUANTUM = 1'b0;
	localparam logic CFG_START   = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LD_SCAN,
		S_LD_SHIFT,
		S_LD_WRITE,
		S_AD_CHECK,
		S_AD_JUMP,
		S_RUN_POP,
		S_RUN_READ,
		S_RUN_EXEC,
		S_AD2_CHECK,
		S_REQUEUE,
		S_RESP
	} state_t;

	typedef enum logic [2:0] {
		RSP_DONE,
		RSP_ACC,
		RSP_REJ,
		RSP_SLICE
	} rsp_t;

	typedef struct packed {
		logic   clear;
		logic   set_running;
		logic   scan_start;
		logic   scan_step;
		logic   shift_step;
		logic   tbl_write;
		logic   admit_push;
		logic   jump;
		logic   pop;
		logic   exec;
		logic   requeue;
		logic   complete;
		logic   rsp_load;
		rsp_t   rsp;
	} cmd_t;

	typedef struct packed {
		logic   running;
		logic   full;
		logic   scan_more;
		logic   shift_more;
		logic   all_done;
		logic   arr_due;
		logic   arr_left;
		logic   ring_empty;
		logic   rem_zero;
	} sts_t;

endpackage

// ----- hw/rtl/rrss_if.sv -----
// ----------------------------------------------------------------------------
// rrss_if
// Valid/ready channel interfaces for requests, results and configuration.
// ----------------------------------------------------------------------------
interface rrss_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] proc_id;
	logic [31:0] arrival_time;
	logic [31:0] burst_time;
	modport source (output valid, kind, proc_id, arrival_time, burst_time, input ready);
	modport sink   (input valid, kind, proc_id, arrival_time, burst_time, output ready);
endinterface

interface rrss_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] slice_id;
	logic [31:0] slice_start;
	logic [31:0] slice_end;
	logic        proc_finished;
	modport source (output valid, status, slice_id, slice_start, slice_end, proc_finished,
		input ready);
	modport sink   (input valid, status, slice_id, slice_start, slice_end, proc_finished,
		output ready);
endinterface

interface rrss_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/rrss_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrss_ctrl
// Sequencer: walks one request through load, admit, run and requeue steps.
// ----------------------------------------------------------------------------
module rrss_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         in_kind,
	output logic               out_valid,
	input  logic               out_ready,
	input  rrss_pkg::sts_t     sts,
	output rrss_pkg::cmd_t     cmd
);

	rrss_pkg::state_t state_q, state_d;
	logic out_valid_q, out_valid_d;
	logic jumped_q, jumped_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rrss_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			jumped_q    <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
			jumped_q    <= jumped_d;
		end
	end

	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == rrss_pkg::S_IDLE) && !out_valid_q;

	always_comb begin
		state_d     = state_q;
		jumped_d    = jumped_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd         = '0;
		cmd.rsp     = rrss_pkg::RSP_DONE;
		unique case (state_q)
			rrss_pkg::S_IDLE: begin
				if (in_valid && in_ready) begin
					unique case (rrss_pkg::kind_t'(in_kind))
						rrss_pkg::KIND_LOAD: begin
							if (sts.running || sts.full) begin
								cmd.rsp = rrss_pkg::RSP_REJ; cmd.rsp_load = 1'b1;
								out_valid_d = 1'b1;
							end else begin
								cmd.scan_start = 1'b1;
								state_d = rrss_pkg::S_LD_SCAN;
							end
						end
						rrss_pkg::KIND_CLEAR: begin
							cmd.clear = 1'b1;
							cmd.rsp = rrss_pkg::RSP_ACC; cmd.rsp_load = 1'b1;
							out_valid_d = 1'b1;
						end
						rrss_pkg::KIND_SLICE: begin
							cmd.set_running = 1'b1;
							jumped_d = 1'b0;
							if (sts.all_done) begin
								cmd.rsp = rrss_pkg::RSP_DONE; cmd.rsp_load = 1'b1;
								out_valid_d = 1'b1;
							end else begin
								state_d = rrss_pkg::S_AD_CHECK;
							end
						end
						default: begin
							cmd.rsp = rrss_pkg::RSP_REJ; cmd.rsp_load = 1'b1;
							out_valid_d = 1'b1;
						end
					endcase
				end
			end
			rrss_pkg::S_LD_SCAN: begin
				if (sts.scan_more) cmd.scan_step = 1'b1;
				else state_d = rrss_pkg::S_LD_SHIFT;
			end
			rrss_pkg::S_LD_SHIFT: begin
				if (sts.shift_more) cmd.shift_step = 1'b1;
				else state_d = rrss_pkg::S_LD_WRITE;
			end
			rrss_pkg::S_LD_WRITE: begin
				cmd.tbl_write = 1'b1;
				cmd.rsp = rrss_pkg::RSP_ACC; cmd.rsp_load = 1'b1;
				state_d = rrss_pkg::S_RESP;
			end
			rrss_pkg::S_AD_CHECK: begin
				if (sts.arr_due) cmd.admit_push = 1'b1;
				else if (sts.ring_empty && sts.arr_left && !jumped_q)
					state_d = rrss_pkg::S_AD_JUMP;
				else if (sts.ring_empty) begin
					cmd.rsp = rrss_pkg::RSP_DONE; cmd.rsp_load = 1'b1;
					state_d = rrss_pkg::S_RESP;
				end else state_d = rrss_pkg::S_RUN_POP;
			end
			rrss_pkg::S_AD_JUMP: begin
				cmd.jump = 1'b1;
				jumped_d = 1'b1;
				state_d = rrss_pkg::S_AD_CHECK;
			end
			rrss_pkg::S_RUN_POP: begin
				cmd.pop = 1'b1;
				state_d = rrss_pkg::S_RUN_READ;
			end
			rrss_pkg::S_RUN_READ: state_d = rrss_pkg::S_RUN_EXEC;
			rrss_pkg::S_RUN_EXEC: begin
				cmd.exec = 1'b1;
				state_d = rrss_pkg::S_AD2_CHECK;
			end
			rrss_pkg::S_AD2_CHECK: begin
				if (sts.arr_due) cmd.admit_push = 1'b1;
				else state_d = rrss_pkg::S_REQUEUE;
			end
			rrss_pkg::S_REQUEUE: begin
				if (sts.rem_zero) cmd.complete = 1'b1;
				else cmd.requeue = 1'b1;
				cmd.rsp = rrss_pkg::RSP_SLICE; cmd.rsp_load = 1'b1;
				state_d = rrss_pkg::S_RESP;
			end
			rrss_pkg::S_RESP: begin
				out_valid_d = 1'b1;
				state_d = rrss_pkg::S_IDLE;
			end
			default: state_d = rrss_pkg::S_IDLE;
		endcase
	end

endmodule

// ----- hw/rtl/rrss_dp.sv -----
// ----------------------------------------------------------------------------
// rrss_dp
// Datapath: process table, ready ring, time and counters, result register.
// ----------------------------------------------------------------------------
module rrss_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_take,
	input  logic [15:0]        in_proc_id,
	input  logic [31:0]        in_arrival_time,
	input  logic [31:0]        in_burst_time,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  rrss_pkg::cmd_t     cmd,
	output rrss_pkg::sts_t     sts,
	output logic [1:0]         status,
	output logic [15:0]        slice_id,
	output logic [31:0]        slice_start,
	output logic [31:0]        slice_end,
	output logic               proc_finished
);

	localparam int IW = rrss_pkg::IDX_W;
	localparam int CW = rrss_pkg::CNT_W;
	localparam int N  = rrss_pkg::MAX_PROCS;

	logic [15:0]   tid_q  [N];
	logic [31:0]   tarr_q [N];
	logic [31:0]   trem_q [N];
	logic [IW-1:0] ring_q [N];

	logic [15:0]   quantum_q;
	logic [31:0]   start_q;
	logic [IW-1:0] head_q;
	logic [CW-1:0] rcount_q, pcount_q, nai_q, done_q;
	logic [31:0]   now_q;
	logic          running_q;

	logic [15:0]   ld_id_q;
	logic [31:0]   ld_arr_q, ld_burst_q;
	logic [CW-1:0] ptr_q;

	logic [IW-1:0] cur_q;
	logic [15:0]   cur_id_q;
	logic [31:0]   cur_rem_q, cur_start_q;

	logic [1:0]    status_q;
	logic [15:0]   sid_q;
	logic [31:0]   sst_q, sen_q;
	logic          fin_q;

	logic [IW-1:0] ptr_ix, nai_ix, tail_ix;
	logic [31:0]   q32, exec_len, nai_arr;
	logic [CW:0]   tail_sum;

	// shift pointer walks down from pcount to the insert point
	logic [CW-1:0] sh_q;
	logic          in_shift;

	assign ptr_ix   = ptr_q[IW-1:0];
	assign nai_ix   = nai_q[IW-1:0];
	assign nai_arr  = tarr_q[nai_ix];
	assign tail_sum = (CW+1)'(head_q) + (CW+1)'(rcount_q);
	assign tail_ix  = (tail_sum >= (CW+1)'(N)) ? IW'(tail_sum - (CW+1)'(N)) : IW'(tail_sum);
	assign q32      = (quantum_q == 16'd0) ? 32'd1 : {16'd0, quantum_q};
	assign exec_len = (cur_rem_q < q32) ? cur_rem_q : q32;

	always_comb begin
		sts.running    = running_q;
		sts.full       = (pcount_q == CW'(N));
		sts.scan_more  = (ptr_q < pcount_q) && ((tarr_q[ptr_ix] < ld_arr_q) ||
			((tarr_q[ptr_ix] == ld_arr_q) && (tid_q[ptr_ix] <= ld_id_q)));
		sts.shift_more = (sh_q != ptr_q);
		sts.all_done   = (done_q >= pcount_q);
		sts.arr_left   = (nai_q < pcount_q);
		sts.arr_due    = sts.arr_left && (nai_arr <= now_q);
		sts.ring_empty = (rcount_q == '0);
		sts.rem_zero   = (cur_rem_q == 32'd0);
	end

	assign in_shift = cmd.shift_step;

	always_ff @(posedge clk) begin
		if (in_take) begin
			ld_id_q    <= in_proc_id;
			ld_arr_q   <= in_arrival_time;
			ld_burst_q <= in_burst_time;
		end
		if (in_shift) begin
			tid_q[sh_q[IW-1:0]]  <= tid_q[IW'(sh_q - CW'(1))];
			tarr_q[sh_q[IW-1:0]] <= tarr_q[IW'(sh_q - CW'(1))];
			trem_q[sh_q[IW-1:0]] <= trem_q[IW'(sh_q - CW'(1))];
		end
		if (cmd.tbl_write) begin
			tid_q[ptr_ix]  <= ld_id_q;
			tarr_q[ptr_ix] <= ld_arr_q;
			trem_q[ptr_ix] <= ld_burst_q;
		end
		if (cmd.admit_push && rcount_q < CW'(N)) ring_q[tail_ix] <= nai_ix;
		if (cmd.requeue && rcount_q < CW'(N)) ring_q[tail_ix] <= cur_q;
		if (cmd.pop) cur_q <= ring_q[head_q];
		if (cmd.exec) begin
			cur_start_q    <= now_q;
			cur_rem_q      <= cur_rem_q - exec_len;
			trem_q[cur_q]  <= cur_rem_q - exec_len;
		end else begin
			cur_id_q  <= tid_q[cur_q];
			if (!cmd.complete && !cmd.requeue) cur_rem_q <= trem_q[cur_q];
		end
		if (cmd.rsp_load) begin
			status_q <= (cmd.rsp == rrss_pkg::RSP_SLICE) ? rrss_pkg::ST_SLICE :
				(cmd.rsp == rrss_pkg::RSP_ACC) ? rrss_pkg::ST_ACCEPTED :
				(cmd.rsp == rrss_pkg::RSP_REJ) ? rrss_pkg::ST_REJECTED : rrss_pkg::ST_DONE;
			if (cmd.rsp == rrss_pkg::RSP_SLICE) begin
				sid_q <= cur_id_q;
				sst_q <= cur_start_q;
				sen_q <= now_q;
				fin_q <= (cur_rem_q == 32'd0);
			end else begin
				sid_q <= '0;
				sst_q <= '0;
				sen_q <= '0;
				fin_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= 16'd1;
			start_q   <= '0;
			head_q    <= '0;
			rcount_q  <= '0;
			pcount_q  <= '0;
			nai_q     <= '0;
			done_q    <= '0;
			now_q     <= '0;
			running_q <= 1'b0;
			ptr_q     <= '0;
			sh_q      <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == rrss_pkg::CFG_QUANTUM) quantum_q <= cfg_data[15:0];
				else start_q <= cfg_data;
			end
			if (cmd.clear) begin
				head_q    <= '0;
				rcount_q  <= '0;
				pcount_q  <= '0;
				nai_q     <= '0;
				done_q    <= '0;
				now_q     <= start_q;
				running_q <= 1'b0;
			end
			if (cmd.set_running) running_q <= 1'b1;
			if (cmd.scan_start) begin
				ptr_q <= '0;
				sh_q  <= pcount_q;
			end
			if (cmd.scan_step) ptr_q <= ptr_q + CW'(1);
			if (in_shift) sh_q <= sh_q - CW'(1);
			if (cmd.tbl_write) pcount_q <= pcount_q + CW'(1);
			if (cmd.admit_push) begin
				nai_q <= nai_q + CW'(1);
				if (rcount_q < CW'(N)) rcount_q <= rcount_q + CW'(1);
			end
			if (cmd.jump) now_q <= nai_arr;
			if (cmd.pop) begin
				head_q   <= (head_q == IW'(N - 1)) ? '0 : head_q + IW'(1);
				rcount_q <= rcount_q - CW'(1);
			end
			if (cmd.exec) now_q <= now_q + exec_len;
			if (cmd.requeue && rcount_q < CW'(N)) rcount_q <= rcount_q + CW'(1);
			if (cmd.complete) done_q <= done_q + CW'(1);
		end
	end

	assign status        = status_q;
	assign slice_id      = sid_q;
	assign slice_start   = sst_q;
	assign slice_end     = sen_q;
	assign proc_finished = fin_q;

endmodule

// ----- hw/rtl/round_robin_slice_scheduler.sv -----
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler
// Round-robin time-slice scheduler over a sorted table of processes.
// ----------------------------------------------------------------------------
// channel  dir  fields
// in_ch    in   kind, proc_id, arrival_time, burst_time
// out_ch   out  status, slice_id, slice_start, slice_end, proc_finished
// cfg_ch   in   index, data (0 time_quantum, 1 start_time)
//
// One request at a time. Load: scan the sorted table, shift entries, write.
// Slice: admit due arrivals, jump time to the next arrival on an empty ring,
// run the head process for up to one quantum, admit again, requeue or finish;
// clear and reject answer from idle. The single sequencer runs every step.
// Reset clears counters and time; table contents are don't-care.
// A result holds until taken; no new request is taken meanwhile.
module round_robin_slice_scheduler (
	input  logic clk,
	input  logic arst_n,
	rrss_in_if.sink    in_ch,
	rrss_out_if.source out_ch,
	rrss_cfg_if.sink   cfg_ch
);

	rrss_pkg::cmd_t cmd;
	rrss_pkg::sts_t sts;
	logic in_take;

	assign cfg_ch.ready = 1'b1;
	assign in_take = in_ch.valid && in_ch.ready;

	rrss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_kind   (in_ch.kind),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rrss_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_take         (in_take),
		.in_proc_id      (in_ch.proc_id),
		.in_arrival_time (in_ch.arrival_time),
		.in_burst_time   (in_ch.burst_time),
		.cfg_we          (cfg_ch.valid),
		.cfg_index       (cfg_ch.index),
		.cfg_data        (cfg_ch.data),
		.cmd             (cmd),
		.sts             (sts),
		.status          (out_ch.status),
		.slice_id        (out_ch.slice_id),
		.slice_start     (out_ch.slice_start),
		.slice_end       (out_ch.slice_end),
		.proc_finished   (out_ch.proc_finished)
	);

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("request taken with result pending");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !sts.ring_empty) else $error("pop from empty ring");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.tbl_write && cmd.shift_step)) else $error("table write collision");

endmodule
